// ----- rtl/core/stg_pkg.sv -----
// Shared widths, constants, flag type and Taylor sine function for the tone generator's table.
package stg_pkg;

   localparam int PHASE_W   = 32;
   localparam int VOLUME_W  = 7;
   localparam int LENGTH_W  = 16;
   localparam int SAMPLE_W  = 16;
   localparam int SINE_W    = 32;
   localparam int PRODUCT_W = SINE_W + VOLUME_W;
   localparam int SCALE_SHIFT = 15;
   localparam int SCALED_W  = PRODUCT_W - SCALE_SHIFT;

   // floor(p / 100) == (p * ceil(2^31 / 100)) >> 31 for every p below 2^24
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 31;
   localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;
   localparam int QUOT_W = SCALED_W + RECIP_W;
   localparam int MAG_W  = QUOT_W - RECIP_SHIFT;

   localparam logic [MAG_W-1:0] POS_LIMIT = 18'd32767;
   localparam logic [MAG_W-1:0] NEG_LIMIT = 18'd32768;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic playing;
      logic last;
      logic negative;
   } stg_flags_type;

   // Taylor series of sin(x) up to the x^15 term, x and result in Q2.30
   function automatic logic [SINE_W-1:0] taylor_sine_q30(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n[0]) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      return sum[SINE_W-1:0];
   endfunction

endpackage

// ----- rtl/core/sine_tone_generator.sv -----
// Tone generator top level: phase accumulator, quarter-wave sine ROM and scaling pipeline.
//
// Usage: each item on the req_ channel is either a start (command high), which loads
// phase step, volume and length and clears the phase, or a sample tick (command low).
// Every item, start or tick, yields exactly one item on the rsp_ channel; a tick during
// a tone carries the sample (playing high), the final one also carries last_sample.
// Start items and ticks while idle give sample zero with playing low.
// Pipeline: the accepting edge loads the ROM read register; the volume product register
// and then the result register follow as the stages advance, and the rsp_ outputs are
// driven straight from the result register. Throughput: one item per cycle while rsp_stall is low; the
// work is split over three stages so that no stage holds more than one multiplier
// (volume product, then reciprocal multiply for the divide by 100).
// Backpressure: each stage advances when empty or when the stage behind it moves, so
// bubbles are squeezed out and new items enter while a result waits on rsp_stall; a
// stalled result holds. req_stall rises only when all three stages are full and held.
// Reset (synchronous, active high) clears the phase, held step, volume, length, the
// active flag and all stage valid bits; the ROM is a constant table and needs no fill.
module sine_tone_generator #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [stg_pkg::PHASE_W-1:0]         req_phase_step,
   input  logic [stg_pkg::VOLUME_W-1:0]        req_volume_percent,
   input  logic [stg_pkg::LENGTH_W-1:0]        req_tone_length,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [stg_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                rsp_playing,
   output logic                                rsp_last_sample
);
   import stg_pkg::*;

   localparam int QSIZE     = 1 << SINE_TABLE_BITS;
   localparam int ROM_DEPTH = QSIZE + 1;
   localparam int POS_W     = SINE_TABLE_BITS + 1;

   typedef logic [SINE_W-1:0] sine_rom_type [ROM_DEPTH];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         rom[k] = taylor_sine_q30((HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Tone state
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [PHASE_W-1:0]  step_ff, step_in;
   logic [VOLUME_W-1:0] volume_ff, volume_in;
   logic [LENGTH_W-1:0] left_ff, left_in;
   logic                active_ff, active_in;

   // Pipeline stages
   logic                s1_valid_ff;
   stg_flags_type       s1_flags_ff, s1_flags_in;
   logic [VOLUME_W-1:0] s1_volume_ff;
   logic [SINE_W-1:0]   s1_sine_ff;
   logic                s2_valid_ff;
   stg_flags_type       s2_flags_ff;
   logic [PRODUCT_W-1:0] s2_product_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                rsp_playing_ff;
   logic                rsp_last_ff;

   logic s1_ready, s2_ready, s3_ready, req_fire;
   logic [1:0]                 quadrant;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [POS_W-1:0]           pos;
   logic [LENGTH_W-1:0]        left_dec;
   logic [SCALED_W-1:0]        scaled;
   logic [QUOT_W-1:0]          quot_wide;
   logic [MAG_W-1:0]           mag, mag_sat;

   // Ready chain: a stage moves when empty or when the next one moves
   assign s3_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign req_fire  = req_valid && s1_ready;

   // Table lookup address from the current phase
   assign quadrant = phase_ff[PHASE_W-1 -: 2];
   assign idx      = phase_ff[PHASE_W-3 -: SINE_TABLE_BITS];
   assign pos      = quadrant[0] ? POS_W'(QSIZE) - {1'b0, idx} : {1'b0, idx};
   assign left_dec = left_ff - LENGTH_W'(1);

   // Next tone state and the flags travelling with the item
   always_comb begin
      phase_in    = phase_ff;
      step_in     = step_ff;
      volume_in   = volume_ff;
      left_in     = left_ff;
      active_in   = active_ff;
      s1_flags_in = '0;
      if (req_fire) begin
         if (req_command == CMD_START) begin
            // abandon any running tone, load the new one
            phase_in  = '0;
            step_in   = req_phase_step;
            volume_in = req_volume_percent;
            left_in   = req_tone_length;
            active_in = (req_tone_length != '0);
         end else if (active_ff) begin
            s1_flags_in.playing  = 1'b1;
            s1_flags_in.negative = quadrant[1];
            s1_flags_in.last     = (left_dec == '0);
            phase_in = phase_ff + step_ff;
            left_in  = left_dec;
            if (left_dec == '0) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         step_ff   <= '0;
         volume_ff <= '0;
         left_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         volume_ff <= volume_in;
         left_ff   <= left_in;
         active_ff <= active_in;
      end
   end

   // Stage 1: ROM read, volume captured alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_sine_ff   <= SINE_ROM[pos];
         s1_flags_ff  <= s1_flags_in;
         s1_volume_ff <= volume_ff;
      end
   end

   // Stage 2: volume times table value
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_product_ff <= PRODUCT_W'(s1_volume_ff) * PRODUCT_W'(s1_sine_ff);
         s2_flags_ff   <= s1_flags_ff;
      end
   end

   // Stage 3: divide by 100 * 2^15 through a shift and a reciprocal multiply, then saturate
   assign scaled    = s2_product_ff[PRODUCT_W-1:SCALE_SHIFT];
   assign quot_wide = QUOT_W'(scaled) * QUOT_W'(RECIP_100);
   assign mag       = quot_wide[QUOT_W-1:RECIP_SHIFT];

   always_comb begin
      mag_sat       = mag;
      rsp_sample_in = '0;
      if (s2_flags_ff.playing) begin
         if (s2_flags_ff.negative) begin
            if (mag > NEG_LIMIT) begin
               mag_sat = NEG_LIMIT;
            end
            rsp_sample_in = SAMPLE_W'((SAMPLE_W + 1)'(1 << SAMPLE_W) - (SAMPLE_W + 1)'(mag_sat));
         end else begin
            if (mag > POS_LIMIT) begin
               mag_sat = POS_LIMIT;
            end
            rsp_sample_in = SAMPLE_W'(mag_sat);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         rsp_sample_ff  <= rsp_sample_in;
         rsp_playing_ff <= s2_flags_ff.playing;
         rsp_last_ff    <= s2_flags_ff.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_playing     = rsp_playing_ff;
   assign rsp_last_sample = rsp_last_ff;

   // A running tone always has samples to go
   a_active_has_length: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (left_ff != '0))
      else $error("active tone with zero samples left");

   // The last flag only comes with a tone sample
   a_last_is_playing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_sample) |-> rsp_playing)
      else $error("last sample flagged on a silent item");

   // Silent items carry a zero sample
   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_playing) |-> (rsp_sample == '0))
      else $error("non-zero sample on a silent item");

   // An accepted item lands in the first stage
   a_fire_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted item lost at the first stage");

   // Tone ends with the last sample
   a_last_ends_tone: assert property (@(posedge clock) disable iff (reset)
      (req_fire && s1_flags_in.last) |=> !active_ff)
      else $error("tone still active after its last sample");

endmodule
